// ----- design/rmq_pkg.sv -----
// shared types and constants for the rotation matrix to quaternion pipeline
package rmq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 18;
    localparam int D_W       = IN_W + 1;
    localparam int ARG_W     = IN_W + 3;
    localparam int SQ_W      = 36;
    localparam int SQ_STAGES = 18;
    localparam int S_W       = 18;
    localparam int REC_W     = 24;
    localparam int REM_W     = S_W + 2;
    localparam int DV_STAGES = REC_W;
    localparam int MAG_W     = D_W + 1;
    localparam int PROD_W    = MAG_W + REC_W;
    localparam int P_W       = PROD_W - FRAC_BITS;

    // first remainder of 2^(2*FRAC_BITS-1) / s once the always-zero high bits are skipped
    localparam logic [REM_W-1:0] DV_REM0 = REM_W'(1) << (2 * FRAC_BITS - 1 - REC_W);
    localparam logic [SQ_W-1:0]  SQ_BIT0 = SQ_W'(1) << (2 * (SQ_STAGES - 1));
    localparam logic signed [ARG_W-1:0] ONE_ARG = ARG_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } br_t;

    typedef struct packed {
        br_t                   br;
        logic                  bad;
        logic signed [D_W-1:0] d0;
        logic signed [D_W-1:0] d1;
        logic signed [D_W-1:0] d2;
    } side_t;

    typedef struct packed {
        side_t           side;
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sq_t;

    typedef struct packed {
        side_t            side;
        logic [S_W-1:0]   s;
        logic [REM_W-1:0] rem;
        logic [REC_W-1:0] q;
    } dv_t;

endpackage

// ----- design/rotation_matrix_to_quaternion_core.sv -----
// top level of the rotation matrix to quaternion pipeline
//
//   channel   signals                          moves
//   input     in_valid / in_ready              nine matrix entries, Q2.16
//   output    out_valid / out_ready            quaternion, branch, not_rotation flag
//
// one request enters per cycle while the output is not stalled; the stages are 1 front stage, 18 square-root
// stages, 24 divider stages, 1 multiplier stage and the output register.
// reset clears only the stage valid bits, the pipeline is empty afterwards.
// every stage loads when it is empty or when the stage after it moves, so bubbles
// close up and a stalled output holds its request without loss or repeat.
module rotation_matrix_to_quaternion_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r0c0,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r0c1,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r0c2,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r1c0,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r1c1,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r1c2,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r2c0,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r2c1,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r2c2,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [rmq_pkg::IN_W-1:0] quat_x,
    output logic signed [rmq_pkg::IN_W-1:0] quat_y,
    output logic signed [rmq_pkg::IN_W-1:0] quat_z,
    output logic signed [rmq_pkg::IN_W-1:0] quat_w,
    output logic [1:0]                      branch_taken,
    output logic                            not_rotation
);
    import rmq_pkg::*;

    logic f_valid, f_ready;
    sq_t  f_data;
    logic s_valid, s_ready;
    dv_t  s_data;
    logic r_valid, r_ready;
    dv_t  r_data;

    // front end
    rmq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mat_r0c0 (mat_r0c0),
        .mat_r0c1 (mat_r0c1),
        .mat_r0c2 (mat_r0c2),
        .mat_r1c0 (mat_r1c0),
        .mat_r1c1 (mat_r1c1),
        .mat_r1c2 (mat_r1c2),
        .mat_r2c0 (mat_r2c0),
        .mat_r2c1 (mat_r2c1),
        .mat_r2c2 (mat_r2c2),
        .dn_valid (f_valid),
        .dn_ready (f_ready),
        .dn_data  (f_data)
    );

    // square root
    rmq_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (f_valid),
        .up_ready (f_ready),
        .up_data  (f_data),
        .dn_valid (s_valid),
        .dn_ready (s_ready),
        .dn_data  (s_data)
    );

    // reciprocal
    rmq_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .up_data  (s_data),
        .dn_valid (r_valid),
        .dn_ready (r_ready),
        .dn_data  (r_data)
    );

    // scaling and output
    rmq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (r_valid),
        .up_ready     (r_ready),
        .up_data      (r_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .quat_w       (quat_w),
        .branch_taken (branch_taken),
        .not_rotation (not_rotation)
    );

    // checks
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_rotation |-> quat_x == 0 && quat_y == 0 && quat_z == 0 && quat_w == 0)
        else $error("flagged request carries nonzero components");

    a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken == BR_TRACE |-> !not_rotation)
        else $error("trace branch flagged as not a rotation");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output stage is empty");

endmodule

// ----- design/rmq_front.sv -----
// branch selection, square-root argument and off-diagonal sums, one register stage
module rmq_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r0c0,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r0c1,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r0c2,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r1c0,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r1c1,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r1c2,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r2c0,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r2c1,
    input  logic signed [rmq_pkg::IN_W-1:0] mat_r2c2,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output rmq_pkg::sq_t                  dn_data
);
    import rmq_pkg::*;

    logic                    valid_reg;
    sq_t                     data_reg;
    sq_t                     data_next;
    logic signed [ARG_W-1:0] a00, a11, a22, tr, arg;
    logic signed [D_W-1:0]   e01, e02, e10, e12, e20, e21;

    assign in_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // pick the branch and form its terms
    always_comb
    begin
        a00 = ARG_W'(mat_r0c0);
        a11 = ARG_W'(mat_r1c1);
        a22 = ARG_W'(mat_r2c2);
        e01 = D_W'(mat_r0c1);
        e02 = D_W'(mat_r0c2);
        e10 = D_W'(mat_r1c0);
        e12 = D_W'(mat_r1c2);
        e20 = D_W'(mat_r2c0);
        e21 = D_W'(mat_r2c1);
        tr  = a00 + a11 + a22;
        data_next = '0;
        if (tr >= 0)
        begin
            data_next.side.br = BR_TRACE;
            arg = tr + ONE_ARG;
            data_next.side.d0 = e21 - e12;
            data_next.side.d1 = e02 - e20;
            data_next.side.d2 = e10 - e01;
        end
        else if (a00 >= a11 && a00 >= a22)
        begin
            data_next.side.br = BR_X;
            arg = a00 - (a11 + a22) + ONE_ARG;
            data_next.side.d0 = e01 + e10;
            data_next.side.d1 = e20 + e02;
            data_next.side.d2 = e21 - e12;
        end
        else if (a11 >= a22)
        begin
            data_next.side.br = BR_Y;
            arg = a11 - (a22 + a00) + ONE_ARG;
            data_next.side.d0 = e12 + e21;
            data_next.side.d1 = e01 + e10;
            data_next.side.d2 = e02 - e20;
        end
        else
        begin
            data_next.side.br = BR_Z;
            arg = a22 - (a00 + a11) + ONE_ARG;
            data_next.side.d0 = e20 + e02;
            data_next.side.d1 = e12 + e21;
            data_next.side.d2 = e10 - e01;
        end
        data_next.side.bad = (arg <= 0);
        data_next.root     = '0;
        if (arg > 0)
            data_next.rem = SQ_W'(arg) << FRAC_BITS;
    end

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            data_reg <= data_next;
    end

endmodule

// ----- design/rmq_sqrt.sv -----
// pipelined integer square root, one result bit per stage from each radicand bit pair
module rmq_sqrt (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  rmq_pkg::sq_t  up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output rmq_pkg::dv_t  dn_data
);
    import rmq_pkg::*;

    logic [SQ_STAGES-1:0] valid_reg;
    sq_t                  data_reg  [SQ_STAGES];
    sq_t                  data_next [SQ_STAGES];
    logic [SQ_STAGES:0]   en;

    // stall chain, a stage loads when empty or when the next one moves
    always_comb
    begin
        en[SQ_STAGES] = dn_ready;
        for (int k = SQ_STAGES - 1; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    // one compare and subtract per stage
    always_comb
    begin
        sq_t             src;
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] cand;
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            src  = (k == 0) ? up_data : data_reg[(k == 0) ? 0 : k - 1];
            bitv = SQ_BIT0 >> (2 * k);
            cand = src.root + bitv;
            data_next[k] = src;
            if (src.rem >= cand)
            begin
                data_next[k].rem  = src.rem - cand;
                data_next[k].root = (src.root >> 1) + bitv;
            end
            else
                data_next[k].root = src.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            for (int k = 0; k < SQ_STAGES; k++)
                if (en[k])
                    valid_reg[k] <= (k == 0) ? up_valid : valid_reg[(k == 0) ? 0 : k - 1];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQ_STAGES; k++)
            if (en[k])
                data_reg[k] <= data_next[k];
    end

    assign up_ready     = en[0];
    assign dn_valid     = valid_reg[SQ_STAGES-1];
    assign dn_data.side = data_reg[SQ_STAGES-1].side;
    assign dn_data.s    = data_reg[SQ_STAGES-1].root[S_W-1:0];
    assign dn_data.rem  = DV_REM0;
    assign dn_data.q    = '0;

endmodule

// ----- design/rmq_recip.sv -----
// pipelined restoring divider for 0.5 / s, one quotient bit per stage
module rmq_recip (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  rmq_pkg::dv_t  up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output rmq_pkg::dv_t  dn_data
);
    import rmq_pkg::*;

    logic [DV_STAGES-1:0] valid_reg;
    dv_t                  data_reg  [DV_STAGES];
    dv_t                  data_next [DV_STAGES];
    logic [DV_STAGES:0]   en;

    // stall chain
    always_comb
    begin
        en[DV_STAGES] = dn_ready;
        for (int k = DV_STAGES - 1; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    // dividend bits below the skipped top are zero, so only a zero shifts in
    always_comb
    begin
        dv_t              src;
        logic [REM_W-1:0] rem2;
        for (int k = 0; k < DV_STAGES; k++)
        begin
            src  = (k == 0) ? up_data : data_reg[(k == 0) ? 0 : k - 1];
            rem2 = src.rem << 1;
            data_next[k] = src;
            if (rem2 >= REM_W'(src.s))
            begin
                data_next[k].rem = rem2 - REM_W'(src.s);
                data_next[k].q   = {src.q[REC_W-2:0], 1'b1};
            end
            else
            begin
                data_next[k].rem = rem2;
                data_next[k].q   = {src.q[REC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            for (int k = 0; k < DV_STAGES; k++)
                if (en[k])
                    valid_reg[k] <= (k == 0) ? up_valid : valid_reg[(k == 0) ? 0 : k - 1];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DV_STAGES; k++)
            if (en[k])
                data_reg[k] <= data_next[k];
    end

    assign up_ready = en[0];
    assign dn_valid = valid_reg[DV_STAGES-1];
    assign dn_data  = data_reg[DV_STAGES-1];

endmodule

// ----- design/rmq_back.sv -----
// scaling multipliers, saturation, component placement and output register
module rmq_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            up_valid,
    output logic                            up_ready,
    input  rmq_pkg::dv_t                    up_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [rmq_pkg::IN_W-1:0] quat_x,
    output logic signed [rmq_pkg::IN_W-1:0] quat_y,
    output logic signed [rmq_pkg::IN_W-1:0] quat_z,
    output logic signed [rmq_pkg::IN_W-1:0] quat_w,
    output logic [1:0]                      branch_taken,
    output logic                            not_rotation
);
    import rmq_pkg::*;

    localparam logic [P_W-1:0] P_MAX = P_W'((1 << (IN_W - 1)) - 1);
    localparam logic [P_W-1:0] P_MIN = P_W'(1 << (IN_W - 1));

    logic                    mul_valid_reg;
    side_t                   side_reg;
    logic [IN_W-1:0]         half_reg;
    logic [PROD_W-1:0]       pa_reg, pb_reg, pc_reg;
    logic                    mul_en;
    logic                    out_en;
    logic                    out_valid_reg;
    logic signed [IN_W-1:0]  qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [IN_W-1:0]  qx_next, qy_next, qz_next, qw_next;
    br_t                     br_reg;
    logic                    bad_reg;
    logic signed [IN_W-1:0]  a, b, c, h;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [D_W-1:0] d);
        logic signed [MAG_W-1:0] e;
        e = MAG_W'(d);
        return (e < 0) ? MAG_W'(-e) : MAG_W'(e);
    endfunction

    // truncate toward zero, then saturate to the field range
    function automatic logic signed [IN_W-1:0] sat_of(input logic [PROD_W-1:0] prod,
                                                     input logic neg);
        logic [P_W-1:0] p;
        p = prod[PROD_W-1:FRAC_BITS];
        if (neg)
            return (p >= P_MIN) ? IN_W'(P_MIN) : IN_W'(-p);
        else
            return (p >= P_MAX) ? IN_W'(P_MAX) : IN_W'(p);
    endfunction

    assign out_en   = !out_valid_reg || out_ready;
    assign mul_en   = !mul_valid_reg || out_en;
    assign up_ready = mul_en;

    // multiplier stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (mul_en)
            mul_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            side_reg <= up_data.side;
            half_reg <= IN_W'(up_data.s >> 1);
            pa_reg   <= PROD_W'(mag_of(up_data.side.d0)) * PROD_W'(up_data.q);
            pb_reg   <= PROD_W'(mag_of(up_data.side.d1)) * PROD_W'(up_data.q);
            pc_reg   <= PROD_W'(mag_of(up_data.side.d2)) * PROD_W'(up_data.q);
        end
    end

    // placement of the components by branch
    always_comb
    begin
        a = sat_of(pa_reg, side_reg.d0 < 0);
        b = sat_of(pb_reg, side_reg.d1 < 0);
        c = sat_of(pc_reg, side_reg.d2 < 0);
        h = half_reg;
        case (side_reg.br)
            BR_TRACE:
            begin
                qx_next = a; qy_next = b; qz_next = c; qw_next = h;
            end
            BR_X:
            begin
                qx_next = h; qy_next = a; qz_next = b; qw_next = c;
            end
            BR_Y:
            begin
                qx_next = b; qy_next = h; qz_next = a; qw_next = c;
            end
            default:
            begin
                qx_next = a; qy_next = b; qz_next = h; qw_next = c;
            end
        endcase
        if (side_reg.bad)
        begin
            qx_next = '0; qy_next = '0; qz_next = '0; qw_next = '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= mul_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            qz_reg  <= qz_next;
            qw_reg  <= qw_next;
            br_reg  <= side_reg.br;
            bad_reg <= side_reg.bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign quat_x       = qx_reg;
    assign quat_y       = qy_reg;
    assign quat_z       = qz_reg;
    assign quat_w       = qw_reg;
    assign branch_taken = br_reg;
    assign not_rotation = bad_reg;

endmodule

// ----- tb/sv/tb_rotation_matrix_to_quaternion_core.sv -----
// testbench for the rotation matrix to quaternion pipeline
module tb_rotation_matrix_to_quaternion_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rmq_pkg::*;

    localparam int FB   = FRAC_BITS;
    localparam int QMAX = 131071;
    localparam int QMIN = -131072;

    typedef logic signed [IN_W-1:0] fx_t;

    typedef struct packed {
        fx_t  x;
        fx_t  y;
        fx_t  z;
        fx_t  w;
        br_t  br;
        logic bad;
    } quat_res_t;

    // expected quaternions, oldest first
    class quat_scoreboard;
        quat_res_t pending[$];
        int        errors;

        function longint sat(longint v);
            if (v > QMAX) return QMAX;
            if (v < QMIN) return QMIN;
            return v;
        endfunction

        function longint isqrt(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // scale a sum or difference by the reciprocal, truncating toward zero
        function longint mul_rec(longint d, longint unsigned rec);
            longint unsigned mag;
            longint unsigned p;
            mag = (d < 0) ? -d : d;
            p = (mag * rec) >> FB;
            if (p > QMAX + 1) p = QMAX + 1;
            return sat(d < 0 ? -longint'(p) : longint'(p));
        endfunction

        function quat_res_t convert(fx_t m[9]);
            longint          e[9];
            longint          tr, arg, d0, d1, d2, a, b, c, half;
            longint unsigned s, rec;
            quat_res_t       r;
            for (int i = 0; i < 9; i++) e[i] = m[i];
            tr = e[0] + e[4] + e[8];
            r = '0;
            if (tr >= 0)
            begin
                r.br = BR_TRACE; arg = tr + (1 << FB);
                d0 = e[7] - e[5]; d1 = e[2] - e[6]; d2 = e[3] - e[1];
            end
            else if (e[0] >= e[4] && e[0] >= e[8])
            begin
                r.br = BR_X; arg = e[0] - (e[4] + e[8]) + (1 << FB);
                d0 = e[1] + e[3]; d1 = e[6] + e[2]; d2 = e[7] - e[5];
            end
            else if (e[4] >= e[8])
            begin
                r.br = BR_Y; arg = e[4] - (e[8] + e[0]) + (1 << FB);
                d0 = e[5] + e[7]; d1 = e[1] + e[3]; d2 = e[2] - e[6];
            end
            else
            begin
                r.br = BR_Z; arg = e[8] - (e[0] + e[4]) + (1 << FB);
                d0 = e[6] + e[2]; d1 = e[5] + e[7]; d2 = e[3] - e[1];
            end
            if (arg <= 0)
            begin
                r.bad = 1'b1;
                return r;
            end
            s = isqrt(longint'(arg) << FB);
            rec = (64'd1 << (2 * FB - 1)) / s;
            half = sat(s >> 1);
            a = mul_rec(d0, rec);
            b = mul_rec(d1, rec);
            c = mul_rec(d2, rec);
            case (r.br)
                BR_TRACE:
                begin
                    r.w = fx_t'(half); r.x = fx_t'(a); r.y = fx_t'(b); r.z = fx_t'(c);
                end
                BR_X:
                begin
                    r.x = fx_t'(half); r.y = fx_t'(a); r.z = fx_t'(b); r.w = fx_t'(c);
                end
                BR_Y:
                begin
                    r.y = fx_t'(half); r.z = fx_t'(a); r.x = fx_t'(b); r.w = fx_t'(c);
                end
                default:
                begin
                    r.z = fx_t'(half); r.x = fx_t'(a); r.y = fx_t'(b); r.w = fx_t'(c);
                end
            endcase
            return r;
        endfunction

        function void note_request(fx_t m[9]);
            pending.push_back(convert(m));
        endfunction

        function void check_result(quat_res_t got);
            quat_res_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.x !== exp_r.x)
            begin
                $display("%0t: quat_x expected %0d got %0d", $time, exp_r.x, got.x);
                errors++;
            end
            if (got.y !== exp_r.y)
            begin
                $display("%0t: quat_y expected %0d got %0d", $time, exp_r.y, got.y);
                errors++;
            end
            if (got.z !== exp_r.z)
            begin
                $display("%0t: quat_z expected %0d got %0d", $time, exp_r.z, got.z);
                errors++;
            end
            if (got.w !== exp_r.w)
            begin
                $display("%0t: quat_w expected %0d got %0d", $time, exp_r.w, got.w);
                errors++;
            end
            if (got.br !== exp_r.br)
            begin
                $display("%0t: branch expected %0d got %0d", $time, exp_r.br, got.br);
                errors++;
            end
            if (got.bad !== exp_r.bad)
            begin
                $display("%0t: not_rotation expected %0b got %0b", $time, exp_r.bad, got.bad);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    fx_t  mat[9];
    logic out_valid;
    logic out_ready;
    fx_t  quat_x, quat_y, quat_z, quat_w;
    logic [1:0] branch_taken;
    logic not_rotation;

    quat_scoreboard sb;
    bit             send_done;

    rotation_matrix_to_quaternion_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mat_r0c0     (mat[0]),
        .mat_r0c1     (mat[1]),
        .mat_r0c2     (mat[2]),
        .mat_r1c0     (mat[3]),
        .mat_r1c1     (mat[4]),
        .mat_r1c2     (mat[5]),
        .mat_r2c0     (mat[6]),
        .mat_r2c1     (mat[7]),
        .mat_r2c2     (mat[8]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .quat_w       (quat_w),
        .branch_taken (branch_taken),
        .not_rotation (not_rotation)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one request, after a random gap; the gap is skipped in bursty stretches
    // valid drops only when a gap follows, so back-to-back requests keep it high
    task automatic send_matrix(input fx_t m[9], input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 9; i++) mat[i] <= m[i];
        sb.note_request(m);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // a random entry, mostly near the unit range and sometimes anywhere
    function automatic fx_t rand_entry();
        if ($urandom_range(0, 3) == 0) return fx_t'($urandom);
        return fx_t'(int'($urandom_range(0, 2 * 65536)) - 65536);
    endfunction

    // a near-rotation from a random unit quaternion, plus some noise
    function automatic void rand_rotation(output fx_t m[9]);
        real q[4];
        real n;
        real r[9];
        for (int i = 0; i < 4; i++) q[i] = real'(int'($urandom_range(0, 2000)) - 1000);
        n = $sqrt(q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3]);
        if (n < 1.0)
        begin
            q[3] = 1.0;
            n = 1.0;
        end
        for (int i = 0; i < 4; i++) q[i] = q[i] / n;
        r[0] = 1 - 2*(q[1]*q[1] + q[2]*q[2]);
        r[1] = 2*(q[0]*q[1] - q[2]*q[3]);
        r[2] = 2*(q[0]*q[2] + q[1]*q[3]);
        r[3] = 2*(q[0]*q[1] + q[2]*q[3]);
        r[4] = 1 - 2*(q[0]*q[0] + q[2]*q[2]);
        r[5] = 2*(q[1]*q[2] - q[0]*q[3]);
        r[6] = 2*(q[0]*q[2] - q[1]*q[3]);
        r[7] = 2*(q[1]*q[2] + q[0]*q[3]);
        r[8] = 1 - 2*(q[0]*q[0] + q[1]*q[1]);
        for (int i = 0; i < 9; i++)
            m[i] = fx_t'($rtoi(r[i] * 65536.0) + int'($urandom_range(0, 64)) - 32);
    endfunction

    // stimulus
    initial
    begin
        fx_t m[9];
        fx_t ext[4];
        sb = new();
        send_done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        for (int i = 0; i < 9; i++) mat[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, half turns about each axis, ties, extremes, bad
        ext[0] = fx_t'(QMAX); ext[1] = fx_t'(QMIN); ext[2] = '0; ext[3] = fx_t'(-1);
        for (int k = 0; k < 16; k++)
        begin
            for (int i = 0; i < 9; i++) m[i] = '0;
            case (k)
                0: begin m[0] = 65536; m[4] = 65536; m[8] = 65536; end
                1: begin m[0] = 65536; m[4] = -65536; m[8] = -65536; end
                2: begin m[0] = -65536; m[4] = 65536; m[8] = -65536; end
                3: begin m[0] = -65536; m[4] = -65536; m[8] = 65536; end
                4: begin m[0] = -30000; m[4] = -30000; m[8] = -30000; end
                5: begin m[0] = -40000; m[4] = -20000; m[8] = -20000; end
                6: begin m[0] = -40000; m[4] = -40000; m[8] = -40000; m[1] = 1; end
                7: for (int i = 0; i < 9; i++) m[i] = fx_t'(QMAX);
                8: for (int i = 0; i < 9; i++) m[i] = fx_t'(QMIN);
                9: begin
                    for (int i = 0; i < 9; i++) m[i] = ext[i % 4];
                end
                10: begin
                    for (int i = 0; i < 9; i++) m[i] = ext[(i + 1) % 4];
                    m[0] = fx_t'(QMIN); m[4] = fx_t'(QMIN); m[8] = fx_t'(QMAX);
                end
                11: begin
                    m[0] = fx_t'(QMIN); m[4] = fx_t'(QMIN); m[8] = -1;
                    m[1] = fx_t'(QMAX); m[3] = fx_t'(QMAX); m[2] = fx_t'(QMIN);
                    m[6] = fx_t'(QMIN);
                end
                12: begin m[0] = -65536; m[4] = -65536; m[8] = 0; end
                13: begin m[0] = -1; m[4] = -1; m[8] = -1; m[5] = fx_t'(QMAX); end
                14: begin m[0] = fx_t'(QMIN); m[4] = fx_t'(QMAX); m[8] = fx_t'(QMIN); end
                default: begin m[0] = -100000; m[4] = -100000; m[8] = fx_t'(QMIN); end
            endcase
            send_matrix(m, 1'b0);
        end

        // random: mostly near-rotations, the rest raw noise
        for (int n = 0; n < 750; n++)
        begin
            if (n == 300)
            begin
                in_valid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge clk);
            end
            if ($urandom_range(0, 9) < 7)
                rand_rotation(m);
            else
                for (int i = 0; i < 9; i++) m[i] = rand_entry();
            send_matrix(m, (n / 50) % 3 == 1);
        end
        in_valid <= 1'b0;
        send_done = 1'b1;
    end

    // result side: random stalls with stall-free stretches
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = (($time / 4000) % 3 == 2) ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_result({quat_x, quat_y, quat_z, quat_w, br_t'(branch_taken), not_rotation});
        end
    end

    // end of run
    initial
    begin
        wait (sb != null);
        @(posedge clk);
        wait (send_done && sb.pending.size() == 0);
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

endmodule
